// ===== sv/ttc_pkg.sv =====
package ttc_pkg;

   localparam int CoordW   = 16;
   localparam int ReqDataW = 6 * CoordW;
   localparam int ValW     = 32;
   localparam int RspDataW = 3 * ValW;
   localparam int RspUserW = 2;

   typedef struct packed {
      logic [ValW-1:0] value;
      logic            sat;
   } ctr_type;

   // round-to-nearest magnitude q plus sign -> clipped two's complement
   function automatic ctr_type clamp_center(input logic [ValW-1:0] q, input logic ovf,
                                            input logic neg);
      ctr_type r;
      priority if (ovf) begin
         r.sat   = 1'b1;
         r.value = neg ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
      end else if (!neg) begin
         r.sat   = q[ValW-1];
         r.value = q[ValW-1] ? {1'b0, {(ValW-1){1'b1}}} : q;
      end else begin
         r.sat   = q > {1'b1, {(ValW-1){1'b0}}};
         r.value = r.sat ? {1'b1, {(ValW-1){1'b0}}} : ({ValW{1'b0}} - q);
      end
      return r;
   endfunction

endpackage

// ===== sv/ttc_div.sv =====
module ttc_div #(
   parameter int NumW  = 60,
   parameter int DenW  = 34,
   parameter int QuoW  = 32,
   parameter int SideW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NumW-1:0]  in_num,
   input  logic [DenW-1:0]  in_den,
   input  logic [SideW-1:0] in_side,
   output logic             out_valid,
   output logic [QuoW-1:0]  out_quot,
   output logic             out_ovf,
   output logic [SideW-1:0] out_side
);

   localparam int CmpW = (NumW > DenW) ? NumW : DenW;

   logic [QuoW:0]      vld_ff;
   logic [DenW-1:0]    rem_ff  [QuoW+1];
   logic [QuoW-1:0]    low_ff  [QuoW+1];
   logic [QuoW-1:0]    quo_ff  [QuoW+1];
   logic [DenW-1:0]    den_ff  [QuoW+1];
   logic [SideW-1:0]   side_ff [QuoW+1];
   logic [QuoW:0]      ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QuoW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DenW'(in_num >> QuoW);
         low_ff[0]  <= in_num[QuoW-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         ovf_ff[0]  <= CmpW'(in_num >> QuoW) >= CmpW'(in_den);
      end
   end

   for (genvar i = 1; i <= QuoW; i++) begin : g_stage
      logic [DenW:0] trial;
      logic [DenW:0] diff;
      logic          ge;

      assign trial = {rem_ff[i-1], low_ff[i-1][QuoW-1]};
      assign ge    = trial >= {1'b0, den_ff[i-1]};
      assign diff  = trial - {1'b0, den_ff[i-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
            low_ff[i]  <= {low_ff[i-1][QuoW-2:0], 1'b0};
            quo_ff[i]  <= {quo_ff[i-1][QuoW-2:0], ge};
            den_ff[i]  <= den_ff[i-1];
            side_ff[i] <= side_ff[i-1];
            ovf_ff[i]  <= ovf_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[QuoW];
   assign out_quot  = quo_ff[QuoW];
   assign out_ovf   = ovf_ff[QuoW];
   assign out_side  = side_ff[QuoW];

endmodule

// ===== sv/ttc_sqrt.sv =====
module ttc_sqrt #(
   parameter int RadW  = 66,
   parameter int SideW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [RadW-1:0]    in_rad,
   input  logic [SideW-1:0]   in_side,
   output logic               out_valid,
   output logic [RadW/2-1:0]  out_root,
   output logic [SideW-1:0]   out_side
);

   localparam int RootW = RadW / 2;
   localparam int RemW  = RootW + 2;

   logic [RootW:0]     vld_ff;
   logic [RadW-1:0]    rad_ff  [RootW+1];
   logic [RemW-1:0]    rem_ff  [RootW+1];
   logic [RootW-1:0]   root_ff [RootW+1];
   logic [SideW-1:0]   side_ff [RootW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RootW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= in_rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 1; i <= RootW; i++) begin : g_stage
      logic [RemW+1:0] cur;
      logic [RemW+1:0] trial;
      logic [RemW+1:0] diff;
      logic            ge;

      assign cur   = {rem_ff[i-1], rad_ff[i-1][RadW-1 -: 2]};
      assign trial = (RemW+2)'({root_ff[i-1], 2'b01});
      assign ge    = cur >= trial;
      assign diff  = cur - trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i]  <= {rad_ff[i-1][RadW-3:0], 2'b00};
            rem_ff[i]  <= ge ? diff[RemW-1:0] : cur[RemW-1:0];
            root_ff[i] <= {root_ff[i-1][RootW-2:0], ge};
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[RootW];
   assign out_root  = root_ff[RootW];
   assign out_side  = side_ff[RootW];

endmodule

// ===== sv/triangle_circumcircle_core.sv =====
// Circumcenter and circumradius of one triangle per transfer.
// req channel: one transfer carries the three vertices a, b, c as signed
//   16-bit integer pixel coordinates.
// rsp channel: one transfer per request, in order: center x and y as signed
//   Q24.8 and radius as unsigned Q24.8, all rounded to nearest and clipped;
//   tuser flags collinear vertices (all values zero) and clipping.
// Path from the req transfer to rsp_tvalid: products and sums, a 33-stage
//   divider for the center (x and y side by side), a 67-stage divider for the
//   squared radius and a 34-stage square root, each retiring one quotient or
//   root bit per stage after its load stage, then the output register.
// Throughput: one triangle per cycle while req_tready is high.
// Reset clears every valid bit; the pipeline is empty afterwards.
// When the receiver stalls, the output register holds its result and a skid
//   register takes one more; only then does req_tready drop and the whole
//   pipeline freeze in place.
module triangle_circumcircle_core
   import ttc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // center_x, center_y, radius
   output logic [RspUserW-1:0] rsp_tuser    // degenerate, saturated
);

   logic en;
   logic skid_valid_ff;
   logic rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff, skid_data_ff;
   logic [RspUserW-1:0] rsp_user_ff, skid_user_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   logic signed [CoordW-1:0] ax, ay, bx, by, cx, cy;
   assign ax = req_tdata[0*CoordW +: CoordW];
   assign ay = req_tdata[1*CoordW +: CoordW];
   assign bx = req_tdata[2*CoordW +: CoordW];
   assign by = req_tdata[3*CoordW +: CoordW];
   assign cx = req_tdata[4*CoordW +: CoordW];
   assign cy = req_tdata[5*CoordW +: CoordW];

   logic [8:1] vld_ff;

   logic signed [16:0]  s1_vx_ff, s1_vy_ff, s1_ux_ff, s1_uy_ff, s1_wx_ff, s1_wy_ff;
   logic signed [17:0]  s1_sx_ff, s1_sy_ff;
   logic signed [33:0]  s2_mvu_ff, s2_myx_ff, s2_mwu_ff, s2_mwv_ff, s2_vxx_ff, s2_vyy_ff;
   logic signed [17:0]  s2_sx_ff, s2_sy_ff;
   logic signed [16:0]  s2_vx_ff, s2_vy_ff;
   logic signed [33:0]  s3_den_ff, s3_num_ff;
   logic [32:0]         s3_vsq_ff;
   logic signed [17:0]  s3_sx_ff, s3_sy_ff;
   logic signed [16:0]  s3_vx_ff, s3_vy_ff;
   logic signed [51:0]  s4_xa_ff, s4_xb_ff, s4_ya_ff, s4_yb_ff;
   logic [32:0]         s4_dmag_ff, s4_nmag_ff, s4_vsq_ff;
   logic                s4_dneg_ff, s4_deg_ff;
   logic signed [51:0]  s5_xs_ff, s5_ys_ff;
   logic [65:0]         s5_dd_ff, s5_nn_ff;
   logic [32:0]         s5_dmag_ff, s5_vsq_ff;
   logic                s5_dneg_ff, s5_deg_ff;
   logic [50:0]         s6_xmag_in, s6_ymag_in;
   logic [59:0]         s6_cnx_ff, s6_cny_ff;
   logic                s6_negx_ff, s6_negy_ff, s6_deg_ff;
   logic [33:0]         s6_cden_ff;
   logic [66:0]         s6_ee_ff;
   logic [65:0]         s6_dd_ff;
   logic [32:0]         s6_vsq_ff;
   logic [66:0]         s7_mlo_ff;
   logic [65:0]         s7_mhi_ff;
   logic [59:0]         s7_cnx_ff, s7_cny_ff;
   logic                s7_negx_ff, s7_negy_ff, s7_deg_ff;
   logic [33:0]         s7_cden_ff;
   logic [65:0]         s7_dd_ff;
   logic [115:0]        s8_mm_ff;
   logic [59:0]         s8_cnx_ff, s8_cny_ff;
   logic                s8_negx_ff, s8_negy_ff, s8_deg_ff;
   logic [33:0]         s8_cden_ff;
   logic [65:0]         s8_dd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[7:1], req_tvalid};
      end
   end

   always_comb begin
      s6_xmag_in = s5_xs_ff[51] ? 51'(-s5_xs_ff) : s5_xs_ff[50:0];
      s6_ymag_in = s5_ys_ff[51] ? 51'(-s5_ys_ff) : s5_ys_ff[50:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // edge vectors and vertex sums
         s1_vx_ff <= 17'(bx) - 17'(ax);
         s1_vy_ff <= 17'(by) - 17'(ay);
         s1_ux_ff <= 17'(cx) - 17'(bx);
         s1_uy_ff <= 17'(cy) - 17'(by);
         s1_wx_ff <= 17'(cx) - 17'(ax);
         s1_wy_ff <= 17'(cy) - 17'(ay);
         s1_sx_ff <= 18'(ax) + 18'(bx);
         s1_sy_ff <= 18'(ay) + 18'(by);

         s2_mvu_ff <= 34'(s1_vx_ff) * 34'(s1_uy_ff);
         s2_myx_ff <= 34'(s1_vy_ff) * 34'(s1_ux_ff);
         s2_mwu_ff <= 34'(s1_wx_ff) * 34'(s1_ux_ff);
         s2_mwv_ff <= 34'(s1_wy_ff) * 34'(s1_uy_ff);
         s2_vxx_ff <= 34'(s1_vx_ff) * 34'(s1_vx_ff);
         s2_vyy_ff <= 34'(s1_vy_ff) * 34'(s1_vy_ff);
         s2_sx_ff  <= s1_sx_ff;
         s2_sy_ff  <= s1_sy_ff;
         s2_vx_ff  <= s1_vx_ff;
         s2_vy_ff  <= s1_vy_ff;

         s3_den_ff <= s2_mvu_ff - s2_myx_ff;
         s3_num_ff <= s2_mwu_ff + s2_mwv_ff;
         s3_vsq_ff <= s2_vxx_ff[32:0] + s2_vyy_ff[32:0];
         s3_sx_ff  <= s2_sx_ff;
         s3_sy_ff  <= s2_sy_ff;
         s3_vx_ff  <= s2_vx_ff;
         s3_vy_ff  <= s2_vy_ff;

         s4_xa_ff   <= 52'(s3_sx_ff) * 52'(s3_den_ff);
         s4_xb_ff   <= 52'(s3_vy_ff) * 52'(s3_num_ff);
         s4_ya_ff   <= 52'(s3_sy_ff) * 52'(s3_den_ff);
         s4_yb_ff   <= 52'(s3_vx_ff) * 52'(s3_num_ff);
         s4_dmag_ff <= s3_den_ff[33] ? 33'(-s3_den_ff) : s3_den_ff[32:0];
         s4_nmag_ff <= s3_num_ff[33] ? 33'(-s3_num_ff) : s3_num_ff[32:0];
         s4_dneg_ff <= s3_den_ff[33];
         s4_deg_ff  <= s3_den_ff == '0;
         s4_vsq_ff  <= s3_vsq_ff;

         s5_xs_ff   <= s4_xa_ff - s4_xb_ff;
         s5_ys_ff   <= s4_ya_ff + s4_yb_ff;
         s5_dd_ff   <= 66'(s4_dmag_ff) * 66'(s4_dmag_ff);
         s5_nn_ff   <= 66'(s4_nmag_ff) * 66'(s4_nmag_ff);
         s5_dmag_ff <= s4_dmag_ff;
         s5_dneg_ff <= s4_dneg_ff;
         s5_deg_ff  <= s4_deg_ff;
         s5_vsq_ff  <= s4_vsq_ff;

         // dividend 2*|128*X| + |D| over divisor 2*|D| rounds half away from zero
         s6_cnx_ff  <= 60'({s6_xmag_in, 8'h00}) + 60'(s5_dmag_ff);
         s6_cny_ff  <= 60'({s6_ymag_in, 8'h00}) + 60'(s5_dmag_ff);
         s6_negx_ff <= s5_xs_ff[51] ^ s5_dneg_ff;
         s6_negy_ff <= s5_ys_ff[51] ^ s5_dneg_ff;
         s6_cden_ff <= {s5_dmag_ff, 1'b0};
         s6_ee_ff   <= 67'(s5_dd_ff) + 67'(s5_nn_ff);
         s6_dd_ff   <= s5_dd_ff;
         s6_vsq_ff  <= s5_vsq_ff;
         s6_deg_ff  <= s5_deg_ff;

         s7_mlo_ff  <= 67'(s6_vsq_ff) * 67'(s6_ee_ff[33:0]);
         s7_mhi_ff  <= 66'(s6_vsq_ff) * 66'(s6_ee_ff[66:34]);
         s7_cnx_ff  <= s6_cnx_ff;
         s7_cny_ff  <= s6_cny_ff;
         s7_negx_ff <= s6_negx_ff;
         s7_negy_ff <= s6_negy_ff;
         s7_cden_ff <= s6_cden_ff;
         s7_dd_ff   <= s6_dd_ff;
         s7_deg_ff  <= s6_deg_ff;

         s8_mm_ff   <= {(100'(s7_mhi_ff) << 34) + 100'(s7_mlo_ff), 16'h0000};
         s8_cnx_ff  <= s7_cnx_ff;
         s8_cny_ff  <= s7_cny_ff;
         s8_negx_ff <= s7_negx_ff;
         s8_negy_ff <= s7_negy_ff;
         s8_cden_ff <= s7_cden_ff;
         s8_dd_ff   <= s7_dd_ff;
         s8_deg_ff  <= s7_deg_ff;
      end
   end

   localparam int XSideW = 1 + 116 + 66 + 1;
   localparam int RSideW = ValW + ValW + 1 + 1;
   localparam int QSideW = RSideW + 1;

   logic              dx_valid, dx_ovf, dy_valid, dy_ovf;
   logic [ValW-1:0]   dx_quot, dy_quot;
   logic [XSideW-1:0] dx_side;
   logic [0:0]        dy_side;
   logic              dx_negx, dx_deg;
   logic [115:0]      dx_mm;
   logic [65:0]       dx_dd;
   ctr_type           ctr_x, ctr_y;

   ttc_div #(.NumW(60), .DenW(34), .QuoW(ValW), .SideW(XSideW)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_ff[8]),
      .in_num    (s8_cnx_ff),
      .in_den    (s8_cden_ff),
      .in_side   ({s8_negx_ff, s8_mm_ff, s8_dd_ff, s8_deg_ff}),
      .out_valid (dx_valid),
      .out_quot  (dx_quot),
      .out_ovf   (dx_ovf),
      .out_side  (dx_side)
   );

   ttc_div #(.NumW(60), .DenW(34), .QuoW(ValW), .SideW(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_ff[8]),
      .in_num    (s8_cny_ff),
      .in_den    (s8_cden_ff),
      .in_side   (s8_negy_ff),
      .out_valid (dy_valid),
      .out_quot  (dy_quot),
      .out_ovf   (dy_ovf),
      .out_side  (dy_side)
   );

   assign {dx_negx, dx_mm, dx_dd, dx_deg} = dx_side;
   assign ctr_x = clamp_center(dx_quot, dx_ovf, dx_negx);
   assign ctr_y = clamp_center(dy_quot, dy_ovf, dy_side[0]);

   logic              dr_valid, dr_ovf;
   logic [65:0]       dr_quot;
   logic [RSideW-1:0] dr_side;

   // floor(65536 * |v|^2 * (D^2 + N^2) / D^2) = (512 * radius)^2, truncated
   ttc_div #(.NumW(116), .DenW(66), .QuoW(66), .SideW(RSideW)) u_div_r (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dx_valid & dy_valid),
      .in_num    (dx_mm),
      .in_den    (dx_dd),
      .in_side   ({ctr_x.value, ctr_y.value, ctr_x.sat | ctr_y.sat, dx_deg}),
      .out_valid (dr_valid),
      .out_quot  (dr_quot),
      .out_ovf   (dr_ovf),
      .out_side  (dr_side)
   );

   logic              sq_valid;
   logic [32:0]       sq_root;
   logic [QSideW-1:0] sq_side;
   logic [ValW-1:0]   sq_cx, sq_cy;
   logic              sq_csat, sq_deg, sq_rovf;

   ttc_sqrt #(.RadW(66), .SideW(QSideW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dr_valid),
      .in_rad    (dr_quot),
      .in_side   ({dr_side, dr_ovf}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {sq_cx, sq_cy, sq_csat, sq_deg, sq_rovf} = sq_side;

   logic [33:0]         rnd_sum;
   logic                rad_sat;
   logic [ValW-1:0]     rad_val;
   logic [RspDataW-1:0] fin_data;
   logic [RspUserW-1:0] fin_user;

   always_comb begin
      // largest R with (2R - 1) <= isqrt(T)
      rnd_sum = 34'(sq_root) + 34'd1;
      rad_sat = sq_rovf | rnd_sum[33];
      rad_val = rad_sat ? {ValW{1'b1}} : rnd_sum[32:1];
      if (sq_deg) begin
         fin_data = '0;
         fin_user = 2'b01;
      end else begin
         fin_data = {rad_val, sq_cy, sq_cx};
         fin_user = {sq_csat | rad_sat, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && !rsp_tready) begin
         if (sq_valid && en) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sq_valid && en;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && !rsp_tready) begin
         if (sq_valid && en) begin
            skid_data_ff <= fin_data;
            skid_user_ff <= fin_user;
         end
      end else if (skid_valid_ff) begin
         rsp_data_ff <= skid_data_ff;
         rsp_user_ff <= skid_user_ff;
      end else begin
         rsp_data_ff <= fin_data;
         rsp_user_ff <= fin_user;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_skid_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds data while output register is empty");

   a_center_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dx_valid == dy_valid)
      else $error("center x and y dividers out of step");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[0]) |-> (rsp_data_ff == '0 && !rsp_user_ff[1]))
      else $error("degenerate result with nonzero payload");

   a_stall_freezes_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && sq_valid && en) |=> !req_tready)
      else $error("input still open after skid register filled");

endmodule

// ===== tb/sv/triangle_circumcircle_core_tb.sv =====
`timescale 1ns / 100ps

module triangle_circumcircle_core_tb
   import ttc_pkg::*;
();

   typedef struct {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [31:0]        radius;
      logic               degenerate;
      logic               saturated;
   } circle_type;

   typedef struct {
      logic [ReqDataW-1:0] tri_data;
      bit                  typed;
      circle_type          want;
   } tri_row_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic [RspUserW-1:0] rsp_tuser;

   circle_type  circle_q[$];
   tri_row_type tri_rows[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          rsp_count = 0;
   int          rx_gap = 0;

   triangle_circumcircle_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [ReqDataW-1:0] pack_tri(int ax, int ay, int bx, int by, int cx,
                                                    int cy);
      logic [15:0] f[6];
      f[0] = ax[15:0]; f[1] = ay[15:0]; f[2] = bx[15:0];
      f[3] = by[15:0]; f[4] = cx[15:0]; f[5] = cy[15:0];
      return {f[5], f[4], f[3], f[2], f[1], f[0]};
   endfunction

   function automatic longint round_half_away(longint n, longint d);
      longint unsigned un, ud, q;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q  = (2 * un + ud) / (2 * ud);
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [31:0] clip_s32(longint x, inout logic sat);
      if (x > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (x < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic circle_type circumcircle(logic [ReqDataW-1:0] d);
      circle_type r;
      longint ax, ay, bx, by, cx, cy, vx, vy, ux, uy, den, num, xs, ys;
      longint unsigned lo, hi, mid, aden, anum, vlen;
      logic [255:0] dd, rhs, lhs, t;
      logic sat;
      ax = longint'($signed(d[15:0]));   ay = longint'($signed(d[31:16]));
      bx = longint'($signed(d[47:32]));  by = longint'($signed(d[63:48]));
      cx = longint'($signed(d[79:64]));  cy = longint'($signed(d[95:80]));
      vx = bx - ax; vy = by - ay;
      ux = cx - bx; uy = cy - by;
      den = vx * uy - vy * ux;
      num = (cx - ax) * ux + (cy - ay) * uy;
      r = '{0, 0, 0, 1'b0, 1'b0};
      if (den == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      sat = 1'b0;
      xs = (ax + bx) * den - vy * num;
      ys = (ay + by) * den + vx * num;
      r.center_x = clip_s32(round_half_away(128 * xs, den), sat);
      r.center_y = clip_s32(round_half_away(128 * ys, den), sat);
      aden = den < 0 ? -den : den;
      anum = num < 0 ? -num : num;
      vlen = longint'(vx * vx + vy * vy) << 16;
      dd  = 256'(aden) * 256'(aden);
      rhs = 256'(vlen) * (dd + 256'(anum) * 256'(anum));
      lo = 0;
      hi = 64'd1 << 32;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         t   = 256'(2 * mid - 1);
         lhs = t * t * dd;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      if (lo > 64'hFFFF_FFFF) begin
         lo  = 64'hFFFF_FFFF;
         sat = 1'b1;
      end
      r.radius    = lo[31:0];
      r.saturated = sat;
      return r;
   endfunction

   function automatic logic [ReqDataW-1:0] random_tri();
      int ax, ay, dx, dy, k, m, ox, oy;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            return pack_tri($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                            $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                            $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300);
         end
         3, 4: begin
            ox = $urandom_range(0, 60000) - 30000;
            oy = $urandom_range(0, 60000) - 30000;
            return pack_tri(ox + $urandom_range(0, 1000) - 500, oy + $urandom_range(0, 1000) - 500,
                            ox + $urandom_range(0, 1000) - 500, oy + $urandom_range(0, 1000) - 500,
                            ox + $urandom_range(0, 1000) - 500, oy + $urandom_range(0, 1000) - 500);
         end
         5, 6: begin
            return {$urandom(), $urandom(), $urandom()};
         end
         7: begin
            ax = $urandom_range(0, 2000) - 1000; ay = $urandom_range(0, 2000) - 1000;
            dx = $urandom_range(0, 200) - 100;   dy = $urandom_range(0, 200) - 100;
            k  = $urandom_range(0, 100) - 50;    m  = $urandom_range(0, 100) - 50;
            return pack_tri(ax, ay, ax + k * dx, ay + k * dy, ax + m * dx, ay + m * dy);
         end
         default: begin
            ax = $urandom_range(0, 2000) - 1000; ay = $urandom_range(0, 2000) - 1000;
            dx = $urandom_range(0, 30000) - 15000; dy = $urandom_range(0, 30000) - 15000;
            return pack_tri(ax, ay, ax + dx, ay + dy, ax - dx + $urandom_range(0, 2) - 1,
                            ay - dy + $urandom_range(0, 2) - 1);
         end
      endcase
   endfunction

   task automatic add_row(logic [ReqDataW-1:0] d, bit typed, circle_type want);
      tri_row_type row;
      row.tri_data = d;
      row.typed    = typed;
      row.want     = want;
      tri_rows.push_back(row);
   endtask

   task automatic send_tri(logic [ReqDataW-1:0] d, circle_type want, int gap);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      circle_q.push_back(want);
   endtask

   always @(negedge clock) begin
      if (rx_gap > 0) begin
         rsp_tready <= 1'b0;
         rx_gap--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      circle_type want;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else if (!reset) idle_cycles++;
      if (idle_cycles >= 3000) begin
         $display("%0t: watchdog expired", $time);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (rsp_tvalid && rsp_tready) begin
         rsp_count++;
         rx_gap = ((rsp_count / 80) % 3 == 1) ? 0 : $urandom_range(0, 12);
         if (circle_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer tdata=%h tuser=%b", $time, rsp_tdata, rsp_tuser);
         end else begin
            want = circle_q.pop_front();
            if (rsp_tdata[31:0] !== want.center_x || rsp_tdata[63:32] !== want.center_y ||
                rsp_tdata[95:64] !== want.radius || rsp_tuser[0] !== want.degenerate ||
                rsp_tuser[1] !== want.saturated) begin
               errors++;
               $display("%0t: expected cx=%h cy=%h r=%h deg=%b sat=%b", $time, want.center_x,
                        want.center_y, want.radius, want.degenerate, want.saturated);
               $display("%0t: actual   cx=%h cy=%h r=%h deg=%b sat=%b", $time,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser[0],
                        rsp_tuser[1]);
            end
         end
      end
   end

   initial begin
      circle_type deg, none;
      logic [ReqDataW-1:0] d;
      int gap;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      deg  = '{0, 0, 0, 1'b1, 1'b0};
      none = '{0, 0, 0, 1'b0, 1'b0};
      add_row(pack_tri(-32768, -32768, -32768, -32768, -32768, -32768), 1, deg);
      add_row(pack_tri(32767, 32767, 32767, 32767, 32767, 32767), 1, deg);
      add_row(pack_tri(0, 0, 0, 0, 0, 0), 1, deg);
      add_row(pack_tri(-32768, 0, 0, 0, 32767, 0), 1, deg);
      add_row(pack_tri(-5, -5, 1, 1, 7, 7), 1, deg);
      add_row(pack_tri(3, 3, 3, 3, 9, -4), 1, deg);
      add_row(pack_tri(0, 0, 2, 0, 0, 2), 0, none);
      add_row(pack_tri(0, 0, 0, 2, 2, 0), 0, none);
      add_row(pack_tri(0, 0, 1, 0, 0, 1), 0, none);
      add_row(pack_tri(0, 0, 3, 0, 0, 1), 0, none);
      add_row(pack_tri(-1, 0, 1, 0, 0, 3), 0, none);
      add_row(pack_tri(-32768, -32768, 32767, -32768, -32768, 32767), 0, none);
      add_row(pack_tri(-32768, 0, 32767, 0, 0, 1), 0, none);
      add_row(pack_tri(-32768, 0, 32767, 0, 0, -1), 0, none);
      add_row(pack_tri(32767, 32767, -32768, 32767, 0, 32766), 0, none);
      add_row(pack_tri(-32768, -32768, 32767, 32767, -32768, 32767), 0, none);
      add_row(pack_tri(0, 0, 30000, 30000, -30000, -29999), 0, none);
      add_row(pack_tri(-1, -1, 1, -1, -1, 1), 0, none);
      add_row(pack_tri(32767, -32768, -32768, 32767, 32767, 32767), 0, none);
      add_row(pack_tri(100, 200, 300, 400, 500, 601), 0, none);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (tri_rows[i]) begin
         send_tri(tri_rows[i].tri_data,
                  tri_rows[i].typed ? tri_rows[i].want : circumcircle(tri_rows[i].tri_data),
                  $urandom_range(0, 12));
      end
      for (int n = 0; n < 600; n++) begin
         if (n == 300) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (circle_q.size() != 0) @(posedge clock);
         end
         d   = random_tri();
         gap = ((n / 50) % 3 == 2) ? 0 : $urandom_range(0, 12);
         send_tri(d, circumcircle(d), gap);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (circle_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && circle_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/ttc_pkg.sv
sv/ttc_div.sv
sv/ttc_sqrt.sv
sv/triangle_circumcircle_core.sv
tb/sv/triangle_circumcircle_core_tb.sv
